// File: sv/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

  // Ring geometry (8 to 12 address bits)
  localparam int RING_BITS = 11;
  localparam int RING_SIZE = 1 << RING_BITS;

  // Match length range and its counter width
  localparam int MIN_LEN  = 3;
  localparam int MAX_LEN  = 18;
  localparam int LEN_BITS = 5;

  // A pair carries at most 12 offset bits
  localparam int OFF_FULL_BITS = 12;

  // Ring fill value after reset (ASCII space)
  localparam logic [7:0] FILL_BYTE = 8'h20;

  typedef logic [RING_BITS-1:0] ring_addr_t;

  // First write position after reset
  localparam ring_addr_t WP_RESET = ring_addr_t'(RING_SIZE - MAX_LEN);

  // Request from the sequencer to the ring memory
  typedef struct packed {
    logic       wr_en;
    ring_addr_t wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    ring_addr_t rd_addr;
  } ring_req_t;

endpackage

`default_nettype wire

// File: sv/lzss_if.sv
`default_nettype none

// Compressed byte channel
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Decompressed byte channel
interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

// File: sv/lzss_ring_mem.sv
`default_nettype none

module lzss_ring_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lzss_pkg::ring_req_t req,
  output logic [7:0]             rd_data,
  output logic                   ready
);

  logic [7:0]           mem [lzss_pkg::RING_SIZE];
  logic [7:0]           rd_data_r;
  lzss_pkg::ring_addr_t clr_addr_r;
  logic                 clr_busy_r;

  logic                 we;
  lzss_pkg::ring_addr_t wa;
  logic [7:0]           wd;

  // Clearing sweep owns the write port after reset
  always_comb begin
    if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = lzss_pkg::FILL_BYTE;
    end else begin
      we = req.wr_en;
      wa = req.wr_addr;
      wd = req.wr_data;
    end
  end

  // Sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Storage: one write, one registered read; a same-cycle write to the
  // read address is forwarded so overlapping copies see the fresh byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req.rd_en) begin
      if (we && (wa == req.rd_addr)) begin
        rd_data_r <= wd;
      end else begin
        rd_data_r <= mem[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

`default_nettype wire

// File: sv/lzss_seq.sv
`default_nettype none

module lzss_seq (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         ring_ready,
  lzss_in_if.sink           in_ch,
  lzss_out_if.source        out_ch,
  output lzss_pkg::ring_req_t ring_req,
  input  wire logic [7:0]   ring_rd_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COPY = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  lzss_pkg::ring_addr_t          wp_r, wp_nxt;
  logic [7:0]                    flag_bits_r, flag_bits_nxt;
  logic [3:0]                    flags_left_r, flags_left_nxt;
  logic                          pair_pending_r, pair_pending_nxt;
  logic [7:0]                    pair_low_r, pair_low_nxt;
  lzss_pkg::ring_addr_t          rd_addr_r, rd_addr_nxt;
  logic [lzss_pkg::LEN_BITS-1:0] rd_left_r, rd_left_nxt;
  logic                          s1_v_r, s1_v_nxt;
  logic                          s1_last_r, s1_last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                                adv;
  logic                                in_ready;
  logic                                in_fire;
  logic [7:0]                          b;
  logic [lzss_pkg::OFF_FULL_BITS-1:0]  off_full;

  // Output register may be loaded when empty or being drained
  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = ring_ready && (state_r == S_IDLE) && adv;
  assign in_fire  = in_ch.valid && in_ready;
  assign b        = in_ch.in_byte;
  assign off_full = {b[7:4], pair_low_r};

  // Decode and copy sequencer
  always_comb begin
    state_nxt        = state_r;
    wp_nxt           = wp_r;
    flag_bits_nxt    = flag_bits_r;
    flags_left_nxt   = flags_left_r;
    pair_pending_nxt = pair_pending_r;
    pair_low_nxt     = pair_low_r;
    rd_addr_nxt      = rd_addr_r;
    rd_left_nxt      = rd_left_r;
    s1_v_nxt         = s1_v_r;
    s1_last_nxt      = s1_last_r;
    out_valid_nxt    = out_valid_r;
    out_byte_nxt     = out_byte_r;
    out_last_nxt     = out_last_r;
    ring_req         = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (flags_left_r == '0) begin
            // flag byte
            flag_bits_nxt    = b;
            flags_left_nxt   = 4'd8;
            pair_pending_nxt = 1'b0;
          end else if (pair_pending_r) begin
            // second pair byte: start copy
            rd_addr_nxt      = off_full[lzss_pkg::RING_BITS-1:0];
            rd_left_nxt      = {1'b0, b[3:0]} + lzss_pkg::LEN_BITS'(lzss_pkg::MIN_LEN);
            s1_v_nxt         = 1'b0;
            pair_pending_nxt = 1'b0;
            flag_bits_nxt    = flag_bits_r >> 1;
            flags_left_nxt   = flags_left_r - 1'b1;
            state_nxt        = S_COPY;
          end else if (flag_bits_r[0]) begin
            // literal
            out_valid_nxt    = 1'b1;
            out_byte_nxt     = b;
            out_last_nxt     = 1'b1;
            ring_req.wr_en   = 1'b1;
            ring_req.wr_addr = wp_r;
            ring_req.wr_data = b;
            wp_nxt           = wp_r + 1'b1;
            flag_bits_nxt    = flag_bits_r >> 1;
            flags_left_nxt   = flags_left_r - 1'b1;
          end else begin
            // first pair byte
            pair_low_nxt     = b;
            pair_pending_nxt = 1'b1;
          end
        end
      end

      S_COPY: begin
        if (adv) begin
          // emit the byte from the last ring read and write it back
          if (s1_v_r) begin
            out_valid_nxt    = 1'b1;
            out_byte_nxt     = ring_rd_data;
            out_last_nxt     = s1_last_r;
            ring_req.wr_en   = 1'b1;
            ring_req.wr_addr = wp_r;
            ring_req.wr_data = ring_rd_data;
            wp_nxt           = wp_r + 1'b1;
          end
          // issue the next read
          if (rd_left_r != '0) begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = rd_addr_r;
            rd_addr_nxt      = rd_addr_r + 1'b1;
            rd_left_nxt      = rd_left_r - 1'b1;
            s1_v_nxt         = 1'b1;
            s1_last_nxt      = (rd_left_r == lzss_pkg::LEN_BITS'(1));
          end else begin
            s1_v_nxt         = 1'b0;
            state_nxt        = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      wp_r           <= lzss_pkg::WP_RESET;
      flag_bits_r    <= '0;
      flags_left_r   <= '0;
      pair_pending_r <= 1'b0;
      pair_low_r     <= '0;
      rd_left_r      <= '0;
      s1_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      wp_r           <= wp_nxt;
      flag_bits_r    <= flag_bits_nxt;
      flags_left_r   <= flags_left_nxt;
      pair_pending_r <= pair_pending_nxt;
      pair_low_r     <= pair_low_nxt;
      rd_left_r      <= rd_left_nxt;
      s1_v_r         <= s1_v_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    s1_last_r   <= s1_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = out_last_r;

  // Group counter never exceeds eight items
  assert property (@(posedge clk) disable iff (!rst_n)
    flags_left_r <= 4'd8)
    else $error("flags_left out of range");

  // Idle means the copy pipeline is drained
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!s1_v_r && (rd_left_r == '0)))
    else $error("copy pipeline not drained in idle");

  // A started copy has a legal length
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_COPY) |=>
      (rd_left_r >= lzss_pkg::LEN_BITS'(lzss_pkg::MIN_LEN) &&
       rd_left_r <= lzss_pkg::LEN_BITS'(lzss_pkg::MAX_LEN)))
    else $error("copy length out of range");

  // Every ring write loads the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    ring_req.wr_en |=> (out_valid_r && $stable(wp_r) == 1'b0))
    else $error("ring write without output byte");

endmodule

`default_nettype wire

// File: sv/lzss_ring_decompressor.sv
`default_nettype none

// Channel   Dir  Payload                      Transfer
// in_ch     in   in_byte[7:0]                 valid & ready
// out_ch    out  out_byte[7:0], run_last      valid & ready
//
// Flag bytes, first pair bytes and literals are each taken in a single transfer.
// A second pair byte starts a copy: its transfer, one ring read per copied
// byte (3..18), and a final write-back of the last copied byte.
// After reset a sweep fills all 2048 ring entries with spaces; no input meanwhile.
// A stalled output freezes the copy; input is taken only when the output
// register is free or draining.

module lzss_ring_decompressor (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lzss_in_if.sink    in_ch,
  lzss_out_if.source out_ch
);

  lzss_pkg::ring_req_t ring_req;
  logic [7:0]          ring_rd_data;
  logic                ring_ready;

  lzss_ring_mem u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ring_req),
    .rd_data (ring_rd_data),
    .ready   (ring_ready)
  );

  lzss_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .ring_ready   (ring_ready),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .ring_req     (ring_req),
    .ring_rd_data (ring_rd_data)
  );

endmodule

`default_nettype wire
